FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

FILE: hdl/vdir_pkg.sv
package vdir_pkg;

   localparam int unsigned IDX_W = 8;
   localparam int unsigned COORD_W = 64;
   localparam logic [COORD_W-1:0] NEG_ZERO = {1'b1, {(COORD_W-1){1'b0}}};

   // Table size; the 8-bit index fields limit it to 256.
   localparam int unsigned MAX_VERTICES = 256;
   localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int unsigned ADDR_W = $clog2(MAX_VERTICES);

   localparam logic ACT_VERTEX = 1'b0;
   localparam logic ACT_FACE = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD_CORNER = 2'd2;

   typedef struct packed {
      logic action;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [COORD_W-1:0] coord_z;
      logic [IDX_W-1:0] corner_a;
      logic [IDX_W-1:0] corner_b;
      logic [IDX_W-1:0] corner_c;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] canon_a;
      logic [IDX_W-1:0] canon_b;
      logic [IDX_W-1:0] canon_c;
      logic first_seen;
      logic [1:0] status;
   } rsp_type;

   // Classified work handed from the front to the back end.
   typedef struct packed {
      logic is_face;
      logic full;
      logic [COORD_W-1:0] kx;
      logic [COORD_W-1:0] ky;
      logic [COORD_W-1:0] kz;
      logic [IDX_W-1:0] corner_a;
      logic [IDX_W-1:0] corner_b;
      logic [IDX_W-1:0] corner_c;
   } work_type;

   function automatic logic [COORD_W-1:0] fold_zero(input logic [COORD_W-1:0] w);
      return (w == NEG_ZERO) ? '0 : w;
   endfunction

endpackage

FILE: hdl/vdir_ram.sv
module vdir_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hdl/vdir_front.sv
module vdir_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  vdir_pkg::req_type    in_req,
   input  logic                 q_ready,
   output logic                 q_valid,
   output vdir_pkg::work_type   q_work,
   output logic                 front_busy
);

   localparam int unsigned MAX_VERTICES = vdir_pkg::MAX_VERTICES;
   localparam int unsigned CNT_W = vdir_pkg::CNT_W;

   // Pending vertices tracked so the full check does not wait for the back end.
   logic [CNT_W-1:0] issued_ff, issued_in;
   logic             q_valid_ff, q_valid_in;
   vdir_pkg::work_type q_work_ff, q_work_in;
   logic             take;

   assign take = in_valid && !q_valid_ff;
   assign front_busy = q_valid_ff;

   always_comb begin
      issued_in = issued_ff;
      q_valid_in = q_valid_ff;
      q_work_in = q_work_ff;
      if (q_valid_ff && q_ready) begin
         q_valid_in = 1'b0;
      end
      if (take) begin
         q_valid_in = 1'b1;
         q_work_in.is_face = (in_req.action == vdir_pkg::ACT_FACE);
         q_work_in.full = (in_req.action == vdir_pkg::ACT_VERTEX) &&
                          (issued_ff == CNT_W'(MAX_VERTICES));
         q_work_in.kx = vdir_pkg::fold_zero(in_req.coord_x);
         q_work_in.ky = vdir_pkg::fold_zero(in_req.coord_y);
         q_work_in.kz = vdir_pkg::fold_zero(in_req.coord_z);
         q_work_in.corner_a = in_req.corner_a;
         q_work_in.corner_b = in_req.corner_b;
         q_work_in.corner_c = in_req.corner_c;
         if (!q_work_in.is_face && !q_work_in.full) begin
            issued_in = issued_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issued_ff <= '0;
         q_valid_ff <= 1'b0;
      end else begin
         issued_ff <= issued_in;
         q_valid_ff <= q_valid_in;
      end
      q_work_ff <= q_work_in;
   end

   assign q_valid = q_valid_ff;
   assign q_work = q_work_ff;

endmodule

FILE: hdl/vdir_back.sv
module vdir_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  vdir_pkg::work_type   q_work,
   output logic                 q_ready,
   output logic                 rsp_strobe,
   output vdir_pkg::rsp_type    rsp_data,
   output logic                 back_busy
);

   localparam int unsigned MAX_VERTICES = vdir_pkg::MAX_VERTICES;
   localparam int unsigned CNT_W = vdir_pkg::CNT_W;
   localparam int unsigned ADDR_W = vdir_pkg::ADDR_W;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_CHECK  = 7'b0000100,
      S_RD_A   = 7'b0001000,
      S_RD_B   = 7'b0010000,
      S_RD_C   = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   localparam int unsigned KEY_W = 3 * vdir_pkg::COORD_W + vdir_pkg::IDX_W;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] vcount_ff, vcount_in;
   logic [CNT_W-1:0] dcount_ff, dcount_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   vdir_pkg::work_type work_ff, work_in;
   vdir_pkg::rsp_type out_ff, out_in;
   logic             strobe_ff, strobe_in;
   logic             bad_ff, bad_in;

   logic              key_we;
   logic [ADDR_W-1:0] key_waddr, key_raddr;
   logic [KEY_W-1:0]  key_wdata, key_rdata;
   logic              map_we;
   logic [ADDR_W-1:0] map_waddr, map_raddr;
   logic [vdir_pkg::IDX_W-1:0] map_wdata, map_rdata;

   vdir_ram #(.WIDTH(KEY_W), .DEPTH(MAX_VERTICES)) u_keys (
      .clock(clock), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(key_wdata),
      .rd_addr(key_raddr), .rd_data(key_rdata)
   );

   vdir_ram #(.WIDTH(vdir_pkg::IDX_W), .DEPTH(MAX_VERTICES)) u_remap (
      .clock(clock), .wr_en(map_we), .wr_addr(map_waddr), .wr_data(map_wdata),
      .rd_addr(map_raddr), .rd_data(map_rdata)
   );

   logic key_hit;
   assign key_hit = (key_rdata[KEY_W-1 -: 3*vdir_pkg::COORD_W] ==
                     {work_ff.kx, work_ff.ky, work_ff.kz});

   function automatic logic corner_ok(input logic [vdir_pkg::IDX_W-1:0] c,
                                      input logic [CNT_W-1:0] n);
      return CNT_W'(c) < n;
   endfunction

   always_comb begin
      state_in = state_ff;
      vcount_in = vcount_ff;
      dcount_in = dcount_ff;
      scan_in = scan_ff;
      work_in = work_ff;
      out_in = out_ff;
      strobe_in = 1'b0;
      bad_in = bad_ff;
      q_ready = 1'b0;
      key_we = 1'b0;
      key_waddr = dcount_ff[ADDR_W-1:0];
      key_wdata = {work_ff.kx, work_ff.ky, work_ff.kz, vcount_ff[vdir_pkg::IDX_W-1:0]};
      key_raddr = scan_ff[ADDR_W-1:0];
      map_we = 1'b0;
      map_waddr = vcount_ff[ADDR_W-1:0];
      map_wdata = vcount_ff[vdir_pkg::IDX_W-1:0];
      map_raddr = work_ff.corner_a[ADDR_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               work_in = q_work;
               out_in = '0;
               bad_in = 1'b0;
               scan_in = '0;
               if (q_work.is_face) begin
                  state_in = S_RD_A;
               end else if (q_work.full) begin
                  out_in.status = vdir_pkg::ST_FULL;
                  strobe_in = 1'b1;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue the read of the current entry, or store a new key when done.
            if (scan_ff == dcount_ff) begin
               key_we = (dcount_ff != CNT_W'(MAX_VERTICES));
               map_we = 1'b1;
               out_in.canon_a = vcount_ff[vdir_pkg::IDX_W-1:0];
               out_in.first_seen = key_we;
               if (key_we) begin
                  dcount_in = dcount_ff + 1'b1;
               end
               vcount_in = vcount_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (key_hit) begin
               map_we = 1'b1;
               map_wdata = key_rdata[vdir_pkg::IDX_W-1:0];
               out_in.canon_a = key_rdata[vdir_pkg::IDX_W-1:0];
               vcount_in = vcount_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               scan_in = scan_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_RD_A: begin
            state_in = S_RD_B;
            key_raddr = '0;
            if (corner_ok(work_ff.corner_a, vcount_ff)) begin
               scan_in = '0;
            end
         end
         S_RD_B: begin
            map_raddr = work_ff.corner_b[ADDR_W-1:0];
            if (corner_ok(work_ff.corner_a, vcount_ff)) out_in.canon_a = map_rdata;
            else bad_in = 1'b1;
            state_in = S_RD_C;
         end
         S_RD_C: begin
            map_raddr = work_ff.corner_c[ADDR_W-1:0];
            if (corner_ok(work_ff.corner_b, vcount_ff)) out_in.canon_b = map_rdata;
            else bad_in = 1'b1;
            state_in = S_DONE;
            scan_in = '1;
         end
         S_DONE: begin
            if (work_ff.is_face) begin
               if (corner_ok(work_ff.corner_c, vcount_ff)) out_in.canon_c = map_rdata;
               else bad_in = 1'b1;
               out_in.status = (bad_in) ? vdir_pkg::ST_BAD_CORNER : vdir_pkg::ST_OK;
            end
            strobe_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vcount_ff <= '0;
         dcount_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vcount_ff <= vcount_in;
         dcount_ff <= dcount_in;
         strobe_ff <= strobe_in;
      end
      scan_ff <= scan_in;
      work_ff <= work_in;
      out_ff <= out_in;
      bad_ff <= bad_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data = out_ff;
   assign back_busy = (state_ff != S_IDLE);

endmodule

FILE: hdl/vertex_dedup_index_remap.sv
// Channel   Ports                          Handshake
// request   start, busy, req_data          taken when start && !busy
// response  rsp_strobe, rsp_data           one cycle, cannot be held off
//
// A vertex scans the stored keys linearly, reading one entry in S_SCAN and comparing it
// in S_CHECK, until a hit or the end; a face passes S_RD_A, S_RD_B, S_RD_C and S_DONE.
// A vertex refused because the table is full is answered from S_IDLE without a scan.
// One request waits in the front register while the back end works.
// Synchronous active-high reset empties both stages and clears the counters.
`include "assert_macros.svh"
module vertex_dedup_index_remap (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  vdir_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output vdir_pkg::rsp_type  rsp_data
);

   logic               q_valid, q_ready, front_busy, back_busy;
   vdir_pkg::work_type q_work;

   vdir_front u_front (
      .clock(clock), .reset(reset), .in_valid(start), .in_req(req_data),
      .q_ready(q_ready), .q_valid(q_valid),
      .q_work(q_work), .front_busy(front_busy)
   );

   vdir_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_work(q_work),
      .q_ready(q_ready), .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data), .back_busy(back_busy)
   );

   assign busy = front_busy;

   `ASSERT_NEVER(a_status_code, clock, reset,
      rsp_strobe && rsp_data.status > vdir_pkg::ST_BAD_CORNER, "illegal status code")
   `ASSERT_IMPL(a_face_no_first, clock, reset,
      !(rsp_strobe && rsp_data.status != vdir_pkg::ST_OK && rsp_data.first_seen),
      "first_seen with error status")
   `ASSERT_IMPL(a_strobe_single, clock, reset,
      rsp_strobe |=> !rsp_strobe || !back_busy, "back-to-back strobe from busy back end")

endmodule

FILE: bench/testbench.sv
module testbench;

   localparam int NUM_VERTS = vdir_pkg::MAX_VERTICES;
   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   vdir_pkg::req_type req_data = '0;
   logic rsp_strobe;
   vdir_pkg::rsp_type rsp_data;

   vertex_dedup_index_remap DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state for the welding tables.
   logic [63:0] key_x [NUM_VERTS];
   logic [63:0] key_y [NUM_VERTS];
   logic [63:0] key_z [NUM_VERTS];
   logic [7:0] key_owner [NUM_VERTS];
   logic [7:0] canon_of [NUM_VERTS];
   int distinct_keys = 0;
   int loaded_verts = 0;

   vdir_pkg::req_type pending_reqs[$];
   vdir_pkg::rsp_type expected_rsps[$];
   int errors = 0;
   int cycles = 0;
   int gap = 0;

   // The first coordinate words picked, reused so that keys repeat often.
   logic [63:0] word_pool[$];

   function automatic void add_req(vdir_pkg::req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic logic [63:0] fold_neg_zero(logic [63:0] w);
      return (w == 64'h8000_0000_0000_0000) ? 64'd0 : w;
   endfunction

   function automatic logic [7:0] remap_corner(logic [7:0] c, ref bit bad);
      if (c >= loaded_verts) begin
         bad = 1'b1;
         return 8'd0;
      end
      return canon_of[c];
   endfunction

   function automatic vdir_pkg::rsp_type weld_predict(vdir_pkg::req_type r);
      vdir_pkg::rsp_type o;
      logic [63:0] kx, ky, kz;
      bit found, bad;
      o = '0;
      found = 1'b0;
      bad = 1'b0;
      if (r.action == vdir_pkg::ACT_VERTEX) begin
         if (loaded_verts >= NUM_VERTS) begin
            o.status = vdir_pkg::ST_FULL;
         end else begin
            kx = fold_neg_zero(r.coord_x);
            ky = fold_neg_zero(r.coord_y);
            kz = fold_neg_zero(r.coord_z);
            o.canon_a = loaded_verts[7:0];
            for (int i = 0; i < distinct_keys; i++) begin
               if (!found && key_x[i] == kx && key_y[i] == ky && key_z[i] == kz) begin
                  o.canon_a = key_owner[i];
                  found = 1'b1;
               end
            end
            if (!found) begin
               key_x[distinct_keys] = kx;
               key_y[distinct_keys] = ky;
               key_z[distinct_keys] = kz;
               key_owner[distinct_keys] = loaded_verts[7:0];
               distinct_keys++;
               o.first_seen = 1'b1;
            end
            canon_of[loaded_verts] = o.canon_a;
            loaded_verts++;
         end
      end else begin
         o.canon_a = remap_corner(r.corner_a, bad);
         o.canon_b = remap_corner(r.corner_b, bad);
         o.canon_c = remap_corner(r.corner_c, bad);
         if (bad) o.status = vdir_pkg::ST_BAD_CORNER;
      end
      return o;
   endfunction

   function automatic logic [63:0] pick_word();
      logic [63:0] w;
      case ($urandom_range(0, 9))
         0: w = 64'd0;
         1: w = 64'h8000_0000_0000_0000;
         2: w = '1;
         3, 4: w = {$urandom, $urandom};
         default: w = word_pool.size() ? word_pool[$urandom_range(0, word_pool.size()-1)]
                                       : {$urandom, $urandom};
      endcase
      if (word_pool.size() < 12) word_pool.insert(word_pool.size(), w);
      return w;
   endfunction

   function automatic vdir_pkg::req_type make_vertex(logic [63:0] x, logic [63:0] y,
                                                     logic [63:0] z);
      vdir_pkg::req_type r;
      r = '0;
      r.action = vdir_pkg::ACT_VERTEX;
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      r.corner_a = 8'($urandom);
      r.corner_b = 8'($urandom);
      r.corner_c = 8'($urandom);
      return r;
   endfunction

   function automatic vdir_pkg::req_type make_face(logic [7:0] a, logic [7:0] b,
                                                   logic [7:0] c);
      vdir_pkg::req_type r;
      r = '0;
      r.action = vdir_pkg::ACT_FACE;
      r.coord_x = {$urandom, $urandom};
      r.coord_y = {$urandom, $urandom};
      r.coord_z = {$urandom, $urandom};
      r.corner_a = a;
      r.corner_b = b;
      r.corner_c = c;
      return r;
   endfunction

   // Model of how many vertices the stimulus has queued, to aim corners.
   int queued_verts = 0;

   function automatic logic [7:0] pick_corner();
      if (queued_verts == 0 || $urandom_range(0, 19) == 0) return 8'($urandom);
      return 8'($urandom_range(0, (queued_verts > 256 ? 256 : queued_verts) - 1));
   endfunction

   initial begin
      // Directed: extremes, signed zero, duplicates, bad corners.
      add_req(make_face(8'd0, 8'd0, 8'd255));
      add_req(make_vertex(64'd0, 64'd0, 64'd0));
      add_req(make_vertex(64'h8000_0000_0000_0000, 64'd0, 64'h8000_0000_0000_0000));
      add_req(make_vertex('1, '1, '1));
      add_req(make_vertex(64'h7FF8_0000_0000_0001, '1, 64'd0));
      add_req(make_vertex('1, '1, '1));
      add_req(make_vertex(64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555,
                          64'h8000_0000_0000_0001));
      add_req(make_face(8'd0, 8'd1, 8'd5));
      add_req(make_face(8'd3, 8'd4, 8'd6));
      add_req(make_face(8'd2, 8'd255, 8'd6));
      queued_verts = 6;
      // Random: up to 300 vertices in all; table resets are impossible, so
      // the table fills once and overflow items are then exercised.
      for (int n = 0; n < 1840; n++) begin
         if (queued_verts < 300 && $urandom_range(0, 2) != 0) begin
            add_req(make_vertex(pick_word(), pick_word(), pick_word()));
            queued_verts++;
         end else begin
            add_req(make_face(pick_corner(), pick_corner(), pick_corner()));
         end
      end
   end

   // Driver.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == 10) reset <= 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            expected_rsps.insert(expected_rsps.size(), weld_predict(req_data));
            void'(pending_reqs.pop_front());
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
                  ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
         end
         if (start && busy) begin
            // hold request
         end else if (gap > 0) begin
            gap--;
            start <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            start <= 1'b1;
            req_data <= pending_reqs[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      vdir_pkg::rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            errors++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data !== exp_rsp) begin
               $display("%0t: mismatch expected %h actual %h", $time, exp_rsp, rsp_data);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (cycles > 12);
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end
endmodule
